>>> src/mba_pkg.sv
package mba_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned IDX_BITS = 3;

	typedef enum logic [2:0] {
		MODE_LOAD_A = 3'd0,
		MODE_LOAD_B = 3'd1,
		MODE_LOAD_M = 3'd2,
		MODE_ADD    = 3'd3,
		MODE_SUB    = 3'd4,
		MODE_MUL    = 3'd5,
		MODE_DIV    = 3'd6,
		MODE_NONE   = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_SUB,
		S_SUBFIX,
		S_DBL,
		S_MADD,
		S_RED,
		S_DLOOP,
		S_DVA,
		S_DFIXA,
		S_DVD,
		S_DVB,
		S_DFIXB,
		S_OUT
	} state_t;

endpackage

>>> src/mba_addsub.sv
module mba_addsub import mba_pkg::*; #(
	parameter int unsigned N = 256
) (
	input  logic [N-1:0] x,
	input  logic [N-1:0] y,
	input  logic         sub,
	output logic [N-1:0] s,
	output logic         cout
);

	logic [N-1:0] y_eff;

	// subtract as x + ~y + 1; cout low then means borrow
	assign y_eff = sub ? ~y : y;
	assign {cout, s} = {1'b0, x} + {1'b0, y_eff} + {{N{1'b0}}, sub};

endmodule

>>> src/modular_big_integer_alu_top.sv
// channel  | handshake          | fields
// ---------+--------------------+----------------------------------------------
// command  | start / busy       | mode, word_index, word_value
// result   | strobe (no stall)  | result_index, result_word, last, error
//
// Add is followed by a reduction, sub by a fix-up on borrow; mul doubles and
// reduces per operand bit (32*WORDS bits), adding b and reducing again for a set
// bit; div runs halving and subtract steps of the binary Euclid loop. All use one
// shared WORDS*32-bit adder/subtractor. Then WORDS result words, one per cycle.
// Reset clears the sequencer and the strobe; operand stores are undefined until
// loaded. busy stays high from an operation start and drops as the last word goes out.
module modular_big_integer_alu_top import mba_pkg::*; #(
	parameter int unsigned WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [2:0]  word_index,
	input  logic [31:0] word_value,
	output logic        strobe,
	output logic [2:0]  result_index,
	output logic [31:0] result_word,
	output logic        last,
	output logic        error
);

	localparam int unsigned N = WORDS * WORD_BITS;
	localparam int unsigned BW = $clog2(N);
	localparam int unsigned CW = (WORDS > 1) ? $clog2(WORDS) : 1;

	state_t state_q, nxt;
	mode_t op_q;
	logic [N-1:0] a_q, b_q, m_q, acc_q, c_q, d_q, tb_q;
	logic car_q, phase_q, err_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] cnt_q;
	logic strobe_q, last_q;
	logic [2:0] ridx_q;
	logic [31:0] rword_q;

	logic [N-1:0] ax, ay, as;
	logic asub, acout;
	logic a_bit, dv_zero, equal;

	mba_addsub #(.N(N)) u_addsub (
		.x(ax), .y(ay), .sub(asub), .s(as), .cout(acout)
	);

	assign a_bit = a_q[bit_q];
	assign dv_zero = (b_q == '0) || (m_q == '0);
	assign equal = (as == '0);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		nxt = state_q;
		ax = acc_q;
		ay = m_q;
		asub = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					priority case (mode_t'(mode))
						MODE_ADD: nxt = S_ADD;
						MODE_SUB: nxt = S_SUB;
						MODE_MUL: nxt = S_DBL;
						MODE_DIV: nxt = dv_zero ? S_OUT : S_DLOOP;
						default: nxt = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				ax = a_q;
				ay = b_q;
				nxt = S_RED;
			end
			S_RED: begin
				asub = 1'b1;
				if (op_q == MODE_MUL) begin
					if (!phase_q && a_bit) nxt = S_MADD;
					else if (bit_q == '0) nxt = S_OUT;
					else nxt = S_DBL;
				end else begin
					nxt = S_OUT;
				end
			end
			S_SUB: begin
				ax = a_q;
				ay = b_q;
				asub = 1'b1;
				nxt = acout ? S_OUT : S_SUBFIX;
			end
			S_SUBFIX: nxt = S_OUT;
			S_DBL: begin
				ay = acc_q;
				nxt = S_RED;
			end
			S_MADD: begin
				ay = b_q;
				nxt = S_RED;
			end
			S_DLOOP: begin
				if (!c_q[0]) begin
					ay = acc_q[0] ? m_q : '0;
				end else if (!d_q[0]) begin
					ax = tb_q;
					ay = tb_q[0] ? m_q : '0;
				end else begin
					ax = c_q;
					ay = d_q;
					asub = 1'b1;
					if (equal) nxt = S_OUT;
					else if (acout) nxt = S_DVA;
					else nxt = S_DVD;
				end
			end
			S_DVA: begin
				ay = tb_q;
				asub = 1'b1;
				nxt = acout ? S_DLOOP : S_DFIXA;
			end
			S_DFIXA: nxt = S_DLOOP;
			S_DVD: begin
				ax = d_q;
				ay = c_q;
				asub = 1'b1;
				nxt = S_DVB;
			end
			S_DVB: begin
				ax = tb_q;
				ay = acc_q;
				asub = 1'b1;
				nxt = acout ? S_DLOOP : S_DFIXB;
			end
			S_DFIXB: begin
				ax = tb_q;
				nxt = S_DLOOP;
			end
			S_OUT: begin
				if (cnt_q == CW'(WORDS - 1)) nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strobe_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= nxt;
			strobe_q <= (state_q == S_OUT);
			if (state_q == S_OUT) cnt_q <= cnt_q + CW'(1);
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q <= mode_t'(mode);
					err_q <= 1'b0;
					priority case (mode_t'(mode))
						MODE_LOAD_A, MODE_LOAD_B, MODE_LOAD_M: begin
							if ({29'd0, word_index} < WORDS) begin
								if (mode_t'(mode) == MODE_LOAD_A)
									a_q[word_index * WORD_BITS +: WORD_BITS] <= word_value;
								else if (mode_t'(mode) == MODE_LOAD_B)
									b_q[word_index * WORD_BITS +: WORD_BITS] <= word_value;
								else
									m_q[word_index * WORD_BITS +: WORD_BITS] <= word_value;
							end
						end
						MODE_MUL: begin
							acc_q <= '0;
							bit_q <= BW'(N - 1);
						end
						MODE_DIV: begin
							if (dv_zero) begin
								acc_q <= '0;
								err_q <= 1'b1;
							end else begin
								acc_q <= a_q;
								tb_q <= '0;
								c_q <= b_q;
								d_q <= m_q;
							end
						end
						default: ;
					endcase
				end
			end
			S_ADD, S_DBL, S_MADD: begin
				acc_q <= as;
				car_q <= acout;
				phase_q <= (state_q == S_MADD);
			end
			S_RED: begin
				if (car_q || acout) acc_q <= as;
				if (!(!phase_q && a_bit)) bit_q <= bit_q - BW'(1);
			end
			S_SUB, S_SUBFIX, S_DVA, S_DFIXA: acc_q <= as;
			S_DLOOP: begin
				if (!c_q[0]) begin
					c_q <= c_q >> 1;
					acc_q <= {acout, as[N-1:1]};
				end else if (!d_q[0]) begin
					d_q <= d_q >> 1;
					tb_q <= {acout, as[N-1:1]};
				end else if (acout) begin
					c_q <= as;
				end
			end
			S_DVD: d_q <= as;
			S_DVB, S_DFIXB: tb_q <= as;
			S_OUT: begin
				rword_q <= acc_q[WORD_BITS-1:0];
				ridx_q <= 3'(cnt_q);
				last_q <= (cnt_q == CW'(WORDS - 1));
				acc_q <= acc_q >> WORD_BITS;
			end
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign result_index = ridx_q;
	assign result_word = rword_q;
	assign last = last_q;
	assign error = err_q;

endmodule

>>> src/mba_checker.sv
module mba_checker import mba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [2:0]  result_index,
	input logic [31:0] result_word,
	input logic        last,
	input logic        error
);

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("word after last");

	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("word right after accepted command");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && result_index == 3'($past(result_index) + 3'd1)
			&& error == $past(error))
		else $error("result burst broken");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && error |-> result_word == 32'd0)
		else $error("error word not zero");

endmodule

bind modular_big_integer_alu_top mba_checker u_mba_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.result_index(result_index), .result_word(result_word), .last(last), .error(error)
);
